// ----- hdl/masked_pixel_temporal_smoother_unit_defines.svh -----
// Assertion macros for the masked pixel temporal smoother RTL.
// Expects clk and rst in the scope of the module that uses them.
`ifndef MASKED_PIXEL_TEMPORAL_SMOOTHER_UNIT_DEFINES_SVH
`define MASKED_PIXEL_TEMPORAL_SMOOTHER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MPTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smoother same-cycle check failed");

// Next-cycle implication.
`define MPTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smoother next-cycle check failed");

`endif

// ----- hdl/mpts_pkg.sv -----
// Shared constants and types for the masked pixel temporal smoother.
// No dependencies.
package mpts_pkg;

  localparam int MAX_WIDTH_DEF      = 1024;
  localparam int MAX_HEIGHT_DEF     = 1024;
  localparam int HIST_FRAC_BITS_DEF = 16;

  localparam int NUM_CH     = 3;
  localparam int COORD_W    = 10;
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 2'd2;

  localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 11'd640;
  localparam logic [ALPHA_W-1:0] ALPHA_RST        = 17'd19661;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE        = 17'd65536;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

endpackage

// ----- hdl/mpts_hist_mem.sv -----
// History memory: one write port, one registered read port with enable.
// Depends on nothing.
module mpts_hist_mem #(
  parameter int AW = 20,
  parameter int DW = 72
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/mpts_front.sv -----
// Front end: request capture, corner mask, first-frame flag and history address.
// Depends on mpts_pkg.
module mpts_front import mpts_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int AW         = $clog2(MAX_WIDTH_DEF) + $clog2(MAX_HEIGHT_DEF)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [COORD_W-1:0]       pixel_col,
  input  logic [COORD_W-1:0]       pixel_row,
  input  pix_t [NUM_CH-1:0]        in_px,
  input  cfg_t                     cfg,
  output logic                     s2_valid,
  output logic [AW-1:0]            s2_addr,
  output pix_t [NUM_CH-1:0]        s2_px,
  output logic                     s2_load
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PROD_W  = 2 * COORD_W + 1;
  localparam int COL_SH  = COORD_W + COL_W;
  localparam int ROW_SH  = COORD_W + ROW_W;
  localparam logic [COORD_W:0] COL_MUL =
    (COORD_W+1)'(((1 << COL_SH) + MAX_WIDTH - 1) / MAX_WIDTH);
  localparam logic [COORD_W:0] ROW_MUL =
    (COORD_W+1)'(((1 << ROW_SH) + MAX_HEIGHT - 1) / MAX_HEIGHT);

  logic                 hist_valid;
  logic                 s1_valid;
  logic [COORD_W-1:0]   s1_col;
  logic [COORD_W-1:0]   s1_row;
  logic [COORD_W-1:0]   s1_qc;
  logic [COORD_W-1:0]   s1_qr;
  pix_t [NUM_CH-1:0]    s1_px;
  logic                 s1_load;
  logic                 masked;
  logic                 frame_end;
  logic [PROD_W-1:0]    col_prod;
  logic [PROD_W-1:0]    row_prod;
  logic [COL_W-1:0]     col_m;
  logic [ROW_W-1:0]     row_m;

  assign masked = ({1'b0, pixel_col} <= (cfg.frame_width >> 2)) &&
                  ({1'b0, pixel_row} <= (cfg.frame_height >> 2));
  assign frame_end = ({1'b0, pixel_col} == cfg.frame_width - DIM_W'(1)) &&
                     ({1'b0, pixel_row} == cfg.frame_height - DIM_W'(1));

  assign col_prod = PROD_W'(pixel_col) * PROD_W'(COL_MUL);
  assign row_prod = PROD_W'(pixel_row) * PROD_W'(ROW_MUL);

  assign col_m = COL_W'(32'(s1_col) - 32'(s1_qc) * 32'(MAX_WIDTH));
  assign row_m = ROW_W'(32'(s1_row) - 32'(s1_qr) * 32'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      if (in_valid && !hist_valid && frame_end) begin
        hist_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col  <= pixel_col;
      s1_row  <= pixel_row;
      s1_qc   <= COORD_W'(col_prod >> COL_SH);
      s1_qr   <= COORD_W'(row_prod >> ROW_SH);
      s1_px   <= masked ? '0 : in_px;
      s1_load <= !hist_valid;
      s2_addr <= {row_m, col_m};
      s2_px   <= s1_px;
      s2_load <= s1_load;
    end
  end

endmodule

// ----- hdl/mpts_lane.sv -----
// One color channel of the history update: multiply stage, then add and clamp.
// Depends on mpts_pkg.
module mpts_lane import mpts_pkg::*; #(
  parameter int HIST_FRAC_BITS = HIST_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [PIX_W+HIST_FRAC_BITS-1:0]   h_in,
  input  pix_t                              px_in,
  input  logic [ALPHA_W-1:0]                alpha,
  output logic [PIX_W+HIST_FRAC_BITS-1:0]   h_out,
  output pix_t                              y
);

  localparam int HW = PIX_W + HIST_FRAC_BITS;
  localparam int DW = HW + 1;
  localparam int PW = ALPHA_W + 1 + DW;
  localparam int SW = PW - ALPHA_FRAC;
  localparam logic signed [PW-1:0] ROUND_Q = PW'(1) << (ALPHA_FRAC - 1);
  localparam logic [HW-1:0] H_TOP = HW'(255) << HIST_FRAC_BITS;
  localparam logic [HW:0]   HALF  = (HW+1)'(1) << (HIST_FRAC_BITS - 1);

  logic [HW-1:0]           s4_h;
  pix_t                    s4_px;
  logic [HW-1:0]           s4_tgt;
  logic signed [DW-1:0]    diff;
  logic signed [ALPHA_W:0] alpha_s;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    s5_prod;
  logic [HW-1:0]           s5_h;
  logic signed [PW-1:0]    prod_rnd;
  logic signed [SW-1:0]    step;
  logic signed [SW:0]      sum;
  logic [HW:0]             out_rnd;
  logic [HW-HIST_FRAC_BITS:0] out_int;

  assign s4_tgt  = HW'(s4_px) << HIST_FRAC_BITS;
  assign diff    = $signed({1'b0, s4_tgt}) - $signed({1'b0, s4_h});
  assign alpha_s = $signed({1'b0, alpha});
  assign prod    = alpha_s * diff;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_h    <= h_in;
      s4_px   <= px_in;
      s5_prod <= prod;
      s5_h    <= s4_h;
    end
  end

  assign prod_rnd = s5_prod + ROUND_Q;
  assign step     = SW'(prod_rnd >>> ALPHA_FRAC);
  assign sum      = $signed((SW+1)'(s5_h)) + step;

  always_comb begin
    if (sum < 0) begin
      h_out = '0;
    end else if (sum > $signed((SW+1)'(H_TOP))) begin
      h_out = H_TOP;
    end else begin
      h_out = HW'(sum);
    end
  end

  assign out_rnd = (HW+1)'(h_out) + HALF;
  assign out_int = out_rnd[HW:HIST_FRAC_BITS];
  assign y = out_int[PIX_W] ? '1 : out_int[PIX_W-1:0];

endmodule

// ----- hdl/masked_pixel_temporal_smoother_unit.sv -----
// Top level of the masked pixel temporal smoother.
// Depends on mpts_pkg, mpts_front, mpts_hist_mem, mpts_lane and the defines header.
//
// Usage: pixels arrive on the input channel (in_valid / in_stall) with their
// column and row; each request yields one smoothed pixel on the output
// channel (out_valid / out_stall). A request is taken at a clock edge with
// valid high and stall low. One request is taken every cycle unless a hazard
// or a stall holds it. A request outside the first frame that updates the
// same history entry as the one just ahead waits for the read-modify-write
// loop around the history memory (multiply, then add and clamp). When the
// receiver stalls, the whole pipeline holds and in_stall rises at once.
// Reset clears the first-frame flag and returns the registers to width 640,
// height 640 and alpha 19661; history memory is not cleared and is filled by
// the first frame. The user writes registers through cfg_we / cfg_index /
// cfg_data only while no request is in flight; the block does not enforce it.
`include "masked_pixel_temporal_smoother_unit_defines.svh"
module masked_pixel_temporal_smoother_unit import mpts_pkg::*; #(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
  parameter int HIST_FRAC_BITS = HIST_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_W-1:0]    pixel_col,
  input  logic [COORD_W-1:0]    pixel_row,
  input  logic [PIX_W-1:0]      in_blue,
  input  logic [PIX_W-1:0]      in_green,
  input  logic [PIX_W-1:0]      in_red,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      out_blue,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_red
);

  localparam int AW = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
  localparam int HW = PIX_W + HIST_FRAC_BITS;
  localparam int MW = NUM_CH * HW;

  cfg_t               cfg;
  logic [ALPHA_W-1:0] alpha_sat;
  logic               run;
  logic               hazard;
  logic               adv;
  pix_t [NUM_CH-1:0]  in_px;

  logic               s2_valid;
  logic [AW-1:0]      s2_addr;
  pix_t [NUM_CH-1:0]  s2_px;
  logic               s2_load;

  logic               s3_valid;
  logic [AW-1:0]      s3_addr;
  pix_t [NUM_CH-1:0]  s3_px;
  logic               s3_load;
  logic               fwd_valid;
  logic [MW-1:0]      fwd_data;
  logic [MW-1:0]      mem_q;
  logic [MW-1:0]      h_sel;

  logic               s4_valid;
  logic [AW-1:0]      s4_addr;
  logic               s4_load;
  logic               s5_valid;
  logic [AW-1:0]      s5_addr;

  logic               wr_en;
  logic [MW-1:0]      wr_data;
  logic [HW-1:0]      lane_h [NUM_CH];
  pix_t [NUM_CH-1:0]  lane_y;

  assign in_px = {in_red, in_green, in_blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.frame_height <= FRAME_HEIGHT_RST;
      cfg.alpha        <= ALPHA_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[DIM_W-1:0];
        CFG_ALPHA:        cfg.alpha        <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;

  assign run      = !out_valid || !out_stall;
  assign hazard   = s3_valid && !s3_load && s4_valid && (s4_addr == s3_addr);
  assign adv      = run && !hazard;
  assign in_stall = !adv;

  mpts_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .in_px     (in_px),
    .cfg       (cfg),
    .s2_valid  (s2_valid),
    .s2_addr   (s2_addr),
    .s2_px     (s2_px),
    .s2_load   (s2_load)
  );

  assign wr_en = run && s5_valid;

  mpts_hist_mem #(
    .AW (AW),
    .DW (MW)
  ) u_hist_mem (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (s2_addr),
    .rd_data (mem_q),
    .wr_en   (wr_en),
    .wr_addr (s5_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        s3_valid <= s2_valid;
      end
      if (run) begin
        s4_valid  <= s3_valid && !hazard;
        s5_valid  <= s4_valid;
        out_valid <= s5_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_addr   <= s2_addr;
      s3_px     <= s2_px;
      s3_load   <= s2_load;
      fwd_valid <= wr_en && (s5_addr == s2_addr);
      fwd_data  <= wr_data;
    end else if (wr_en && (s5_addr == s3_addr)) begin
      fwd_valid <= 1'b1;
      fwd_data  <= wr_data;
    end
    if (run) begin
      s4_addr   <= s3_addr;
      s4_load   <= s3_load;
      s5_addr   <= s4_addr;
      out_blue  <= lane_y[0];
      out_green <= lane_y[1];
      out_red   <= lane_y[2];
    end
  end

  always_comb begin
    if (s5_valid && (s5_addr == s3_addr)) begin
      h_sel = wr_data;
    end else if (fwd_valid) begin
      h_sel = fwd_data;
    end else begin
      h_sel = mem_q;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    logic [HW-1:0] h_in;

    assign h_in = s3_load ? (HW'(s3_px[c]) << HIST_FRAC_BITS) : h_sel[c*HW +: HW];

    mpts_lane #(
      .HIST_FRAC_BITS (HIST_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (run),
      .h_in  (h_in),
      .px_in (s3_px[c]),
      .alpha (alpha_sat),
      .h_out (lane_h[c]),
      .y     (lane_y[c])
    );

    assign wr_data[c*HW +: HW] = lane_h[c];
  end

  `MPTS_ASSERT_IMP(a_no_back_to_back_update, s4_valid && s5_valid && (s4_addr == s5_addr), s4_load)
  `MPTS_ASSERT_NXT(a_hazard_holds_item, hazard, s3_valid)
  `MPTS_ASSERT_NXT(a_no_repeat, out_valid && !out_stall && !s5_valid, !out_valid)

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for masked_pixel_temporal_smoother_unit: random pixel requests
// against an in-bench model of the masked per-pixel moving average.
// Depends on mpts_pkg and the unit's RTL.
module testbench;
  import mpts_pkg::*;

  localparam int FRAC = HIST_FRAC_BITS_DEF;
  localparam int HW = PIX_W + FRAC;
  localparam int RESULT_LATENCY = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CHOKE_AT = 300;
  localparam int CHOKE_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pix_t blue;
    pix_t green;
    pix_t red;
  } pixel_req_t;

  typedef struct packed {
    pix_t blue;
    pix_t green;
    pix_t red;
  } smoothed_px_t;

  typedef logic [NUM_CH-1:0][HW-1:0] hist_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COORD_W-1:0] pixel_col = '0;
  logic [COORD_W-1:0] pixel_row = '0;
  pix_t in_blue = '0;
  pix_t in_green = '0;
  pix_t in_red = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pix_t out_blue;
  pix_t out_green;
  pix_t out_red;

  masked_pixel_temporal_smoother_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .pixel_col(pixel_col), .pixel_row(pixel_row),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red)
  );

  always #2 clk = ~clk;

  logic [DIM_W-1:0] cur_width = FRAME_WIDTH_RST;
  logic [DIM_W-1:0] cur_height = FRAME_HEIGHT_RST;
  logic [ALPHA_W-1:0] cur_alpha = ALPHA_RST;
  bit frame_loaded = 1'b0;
  hist_t hist_mem [int];
  bit loaded_addr [int];
  int loaded_list [$];

  pixel_req_t pixel_q [$];
  smoothed_px_t smoothed_q [$];
  int errors = 0;
  int out_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int choke_left = 0;
  bit choke_done = 1'b0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %0d at result %0d: %s got %0d expected %0d",
             errors, out_count, what, got, want);
  endtask

  function automatic bit frame_end_at(input int col, input int row);
    logic [DIM_W-1:0] end_col;
    logic [DIM_W-1:0] end_row;
    end_col = cur_width - 1'b1;
    end_row = cur_height - 1'b1;
    return (DIM_W'(col) == end_col) && (DIM_W'(row) == end_row);
  endfunction

  function automatic logic [HW-1:0] ema_step(input logic [HW-1:0] h, input pix_t x,
                                             input logic [ALPHA_W-1:0] a);
    longint hv, xv, av, prod, r;
    hv = longint'(h);
    xv = longint'(x);
    xv = xv << FRAC;
    av = longint'(a);
    prod = av * (xv - hv) + 32768;
    r = hv + (prod >>> ALPHA_FRAC);
    if (r < 0) r = 0;
    if (r > (longint'(255) << FRAC)) r = longint'(255) << FRAC;
    return HW'(r);
  endfunction

  function automatic pix_t round_to_pix(input logic [HW-1:0] h);
    longint v;
    v = longint'(h);
    v = (v + (longint'(1) << (FRAC - 1))) >> FRAC;
    return (v > 255) ? pix_t'(255) : pix_t'(v);
  endfunction

  task automatic smooth_pixel(input pixel_req_t req);
    pix_t px [NUM_CH];
    pix_t res [NUM_CH];
    logic [ALPHA_W-1:0] a;
    hist_t h;
    int addr;
    px[0] = req.blue;
    px[1] = req.green;
    px[2] = req.red;
    if (int'(req.col) <= int'(cur_width) / 4 && int'(req.row) <= int'(cur_height) / 4) begin
      for (int c = 0; c < NUM_CH; c++) px[c] = '0;
    end
    addr = int'(req.row) * MAX_WIDTH_DEF + int'(req.col);
    a = (cur_alpha > ALPHA_ONE) ? ALPHA_ONE : cur_alpha;
    if (!frame_loaded) begin
      for (int c = 0; c < NUM_CH; c++) begin
        h[c] = HW'(px[c]) << FRAC;
        res[c] = px[c];
      end
      if (!loaded_addr.exists(addr)) begin
        loaded_addr[addr] = 1'b1;
        loaded_list.push_back(addr);
      end
      if (frame_end_at(int'(req.col), int'(req.row))) frame_loaded = 1'b1;
    end else begin
      h = hist_mem.exists(addr) ? hist_mem[addr] : '0;
      for (int c = 0; c < NUM_CH; c++) begin
        h[c] = ema_step(h[c], px[c], a);
        res[c] = round_to_pix(h[c]);
      end
    end
    hist_mem[addr] = h;
    smoothed_q.push_back({res[0], res[1], res[2]});
  endtask

  // driver
  always @(posedge clk) begin
    pixel_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) smooth_pixel({pixel_col, pixel_row, in_blue, in_green, in_red});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 && !quiet) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          nxt = pixel_q.pop_front();
          pixel_col <= nxt.col;
          pixel_row <= nxt.row;
          in_blue <= nxt.blue;
          in_green <= nxt.green;
          in_red <= nxt.red;
          in_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 19);
          else gap_left <= 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    smoothed_px_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_count++;
        if (smoothed_q.size() == 0) begin
          report_mismatch("unexpected pixel, blue", int'(out_blue), 0);
        end else begin
          want = smoothed_q.pop_front();
          if (out_blue !== want.blue)
            report_mismatch("out_blue", int'(out_blue), int'(want.blue));
          if (out_green !== want.green)
            report_mismatch("out_green", int'(out_green), int'(want.green));
          if (out_red !== want.red)
            report_mismatch("out_red", int'(out_red), int'(want.red));
        end
      end
      if (!choke_done && out_count >= CHOKE_AT) begin
        choke_done = 1'b1;
        choke_left = CHOKE_CYCLES;
      end
      if (choke_left > 0) begin
        choke_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0 && !quiet) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pix_t rand_channel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? pix_t'(255) : pix_t'(0);
    return pix_t'($urandom_range(0, 255));
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  task automatic push_pixel(input int col, input int row, input pix_t b, input pix_t g,
                            input pix_t r);
    pixel_q.push_back({COORD_W'(col), COORD_W'(row), b, g, r});
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pixel_q.size() != 0 || in_valid || smoothed_q.size() != 0);
    repeat (RESULT_LATENCY) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [ALPHA_W-1:0] a, input bit spare);
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    @(posedge clk);
    word = CFG_DATA_W'($urandom);
    word[DIM_W-1:0] = w;
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= word;
    @(posedge clk);
    word = CFG_DATA_W'($urandom);
    word[DIM_W-1:0] = h;
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= word;
    @(posedge clk);
    cfg_index <= CFG_ALPHA;
    cfg_data <= a;
    if (spare) begin
      @(posedge clk);
      cfg_index <= CFG_SPARE;
      cfg_data <= CFG_DATA_W'($urandom);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_width = w;
    cur_height = h;
    cur_alpha = a;
  endtask

  task automatic load_phase(input int n);
    int col, row;
    for (int i = 0; i < n; i++) begin
      do begin
        if ($urandom_range(0, 3) == 0) begin
          col = clamp_coord(int'(cur_width) / 4 + int'($urandom_range(0, 2)) - 1);
          row = clamp_coord(int'(cur_height) / 4 + int'($urandom_range(0, 2)) - 1);
        end else begin
          col = $urandom_range(0, 1023);
          row = $urandom_range(0, 1023);
        end
      end while (frame_end_at(col, row));
      push_pixel(col, row, rand_channel(), rand_channel(), rand_channel());
    end
  endtask

  task automatic smooth_phase(input int n);
    int addr, pick;
    addr = loaded_list[0];
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick >= 6) addr = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      else if (pick >= 3) addr = loaded_list[$urandom_range(0, 7)];
      push_pixel(addr % MAX_WIDTH_DEF, addr / MAX_WIDTH_DEF,
                 rand_channel(), rand_channel(), rand_channel());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first frame under reset settings
    push_pixel(0, 0, 255, 255, 255);
    push_pixel(160, 160, 255, 0, 255);
    push_pixel(161, 160, 255, 255, 255);
    push_pixel(160, 161, 0, 255, 0);
    push_pixel(1023, 1023, 0, 0, 0);
    push_pixel(1023, 0, 255, 255, 255);
    push_pixel(0, 1023, 128, 1, 254);
    push_pixel(638, 639, 85, 170, 255);
    push_pixel(639, 638, 170, 85, 0);

    apply_settings(0, 0, ALPHA_RST, 1'b1);
    push_pixel(0, 0, 255, 255, 255);
    push_pixel(1, 0, 255, 255, 255);
    push_pixel(0, 1, 255, 255, 255);
    push_pixel(1023, 1023, 255, 255, 255);
    load_phase(45);

    apply_settings(1, 1, ALPHA_W'($urandom_range(0, 131071)), 1'b0);
    push_pixel(0, 1, 200, 100, 50);
    push_pixel(1, 0, 50, 100, 200);
    load_phase(45);

    apply_settings(1024, 1024, ALPHA_W'($urandom_range(0, 131071)), 1'b0);
    push_pixel(256, 256, 255, 255, 255);
    push_pixel(257, 256, 255, 255, 255);
    push_pixel(256, 257, 255, 255, 255);
    load_phase(45);

    apply_settings(DIM_W'($urandom_range(1, 1024)), DIM_W'($urandom_range(1, 1024)),
                   ALPHA_ONE, 1'b0);
    load_phase(50);

    // end the first frame at the last pixel of the largest frame
    apply_settings(1024, 1024, ALPHA_RST, 1'b0);
    load_phase(40);
    push_pixel(1023, 1023, 200, 30, 255);

    apply_settings(1024, 1024, 0, 1'b0);
    push_pixel(1023, 1023, 0, 255, 0);
    push_pixel(1023, 1023, 255, 0, 255);
    push_pixel(0, 0, 255, 255, 255);
    smooth_phase(80);

    apply_settings(1024, 1024, ALPHA_ONE, 1'b0);
    push_pixel(1023, 1023, 17, 200, 99);
    push_pixel(1023, 1023, 255, 0, 128);
    smooth_phase(80);

    apply_settings(640, 640, 131071, 1'b0);
    smooth_phase(80);

    apply_settings(0, 0, ALPHA_RST, 1'b0);
    push_pixel(0, 0, 255, 255, 255);
    push_pixel(1, 0, 255, 255, 255);
    smooth_phase(80);

    repeat (2) begin
      apply_settings(DIM_W'($urandom_range(1, 1024)), DIM_W'($urandom_range(1, 1024)),
                     ALPHA_W'($urandom_range(0, 65536)), 1'b0);
      smooth_phase(100);
    end

    apply_settings(DIM_W'($urandom_range(1, 1024)), DIM_W'($urandom_range(1, 1024)),
                   ALPHA_RST, 1'b0);
    quiet = 1'b1;
    smooth_phase(100);

    wait_idle();
    repeat (20) @(negedge clk);
    while (smoothed_q.size() != 0) begin
      report_mismatch("missing pixel, blue", 0, int'(smoothed_q[0].blue));
      void'(smoothed_q.pop_front());
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
